[hw/rtl/sog_pkg.sv]
// ----------------------------------------------------------------------------
// Sum-of-sines generator package
// Shared widths, register indexes, request codes and sine table constants.
// ----------------------------------------------------------------------------
package sog_pkg;

  localparam int MAX_WAVES_DEF  = 6;
  localparam int SINE_DEPTH_DEF = 256;

  localparam int ACTIVE_W = 3;
  localparam int SETUP_W  = 48;
  localparam int CFG_IDX_W = 3;
  localparam int Q16_W    = 16;
  localparam int SUM_W    = 18;

  // 17 x 17 signed shared multiplier, 34-bit product
  localparam int MUL_IN_W  = 17;
  localparam int MUL_OUT_W = 34;
  // accumulator covers six products of magnitude up to 2^29
  localparam int ACC_W     = 34;

  // sine magnitude, Q14 in [0, 16384]
  localparam int SIN_W = 15;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 18'sd131071;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -18'sd131072;

  typedef enum logic {
    REQ_TICK   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETUP0 = 3'd1;

  // Taylor series for the table: Q30 angle, divisors 2^30 * (2n)(2n+1)
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] TAYLOR_DIV [1:7] = '{
    ONE_Q30 * 64'd6,   ONE_Q30 * 64'd20,  ONE_Q30 * 64'd42,  ONE_Q30 * 64'd72,
    ONE_Q30 * 64'd110, ONE_Q30 * 64'd156, ONE_Q30 * 64'd210
  };

endpackage

[hw/rtl/sum_of_sines_generator.sv]
// ----------------------------------------------------------------------------
// Sum-of-sines generator
// Per-wave phase accumulators in turns; tick requests advance the phases,
// sample requests return the amplitude-weighted sum of table sines.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | request   | in_valid / in_stall  | req_type, frame_delta, position
//  out     | result    | out_valid / out_stall| sample_sum (samples only)
//  cfg     | write     | cfg_write            | cfg_index, cfg_data
//
// One shared 17x17 multiplier and the sine table are visited wave by wave.
// A tick steps each active wave through a multiply and a phase update; a sample
// steps each through angle multiply, lookup, table read, amplitude multiply and
// accumulate, and a sample with no active waves goes straight to its output step.
// in_stall is high from the accepting edge until the sequencer is idle again.
// A finished sample waits in the output register; a new request is accepted
// while it waits, and the next sample holds in its last step until it drains.
// Reset (rst, synchronous) clears the phases and setup registers at once.
// ----------------------------------------------------------------------------
module sum_of_sines_generator
  import sog_pkg::*;
#(
  parameter int MAX_WAVES        = MAX_WAVES_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     req_type,
  input  logic [Q16_W-1:0]         frame_delta,
  input  logic [Q16_W-1:0]         position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SUM_W-1:0]  sample_sum,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SETUP_W-1:0]       cfg_data
);

  localparam int WIDX  = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;
  localparam int KW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int RPW   = 14 + KW;
  localparam logic [KW-1:0] DEPTH_K = KW'(SINE_TABLE_DEPTH);
  localparam logic [ACTIVE_W-1:0] MAX_N = ACTIVE_W'(MAX_WAVES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_MUL,
    ST_TICK_UPD,
    ST_ANG_MUL,
    ST_LOOK,
    ST_READ,
    ST_AMP_MUL,
    ST_ACC
  } state_t;

  // --------------------------------------------------------------------------
  // Quarter-wave sine table, built at elaboration
  // --------------------------------------------------------------------------
  function automatic logic [SIN_W-1:0] sine_entry(input int k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        mag;
    logic signed [63:0] acc_s;
    logic [63:0]        v;
    int                 n;
    x     = HALF_PI_Q30 * 64'(k) / 64'(SINE_TABLE_DEPTH);
    x2    = (x * x) >> 30;
    mag   = x;
    acc_s = signed'(x);
    for (n = 1; n <= 7; n++) begin
      mag = mag * x2 / TAYLOR_DIV[n];
      if (n % 2 == 1) acc_s = acc_s - signed'(mag);
      else            acc_s = acc_s + signed'(mag);
    end
    if (acc_s < 0) acc_s = '0;
    v = (unsigned'(acc_s) + 64'd32768) >> 16;
    if (v > 64'd16384) v = 64'd16384;
    return v[SIN_W-1:0];
  endfunction

  logic [SIN_W-1:0] sine_tbl [SINE_TABLE_DEPTH+1];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tbl
    assign sine_tbl[g] = sine_entry(g);
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                       state;
  logic [ACTIVE_W-1:0]          active_waves;
  logic [SETUP_W-1:0]           wave_setup [MAX_WAVES];
  logic [Q16_W-1:0]             wave_phase [MAX_WAVES];
  logic [WIDX-1:0]              wave_idx;
  logic [Q16_W-1:0]             operand;
  logic signed [MUL_OUT_W-1:0]  mul_q;
  logic [KW-1:0]                tbl_idx;
  logic                         negate;
  logic signed [Q16_W-1:0]      sine_q;
  logic signed [ACC_W-1:0]      acc;

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic [ACTIVE_W-1:0]          n_waves;
  logic                         last_wave;
  logic [SETUP_W-1:0]           cur_setup;
  logic signed [MUL_IN_W-1:0]   mul_a;
  logic signed [MUL_IN_W-1:0]   mul_b;
  logic [Q16_W-1:0]             angle;
  logic [RPW-1:0]               r_scaled;
  logic [KW-1:0]                k_raw;
  logic [KW-1:0]                k_clip;
  logic                         out_free;

  assign n_waves   = (active_waves > MAX_N) ? MAX_N : active_waves;
  assign last_wave = (ACTIVE_W'(wave_idx) == n_waves - ACTIVE_W'(1));
  assign cur_setup = wave_setup[wave_idx];
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      ST_TICK_MUL: begin
        mul_a = signed'({1'b0, operand});
        mul_b = MUL_IN_W'(signed'(cur_setup[47:32]));
      end
      ST_ANG_MUL: begin
        mul_a = signed'({1'b0, operand});
        mul_b = signed'({1'b0, cur_setup[31:16]});
      end
      ST_AMP_MUL: begin
        mul_a = MUL_IN_W'(signed'(cur_setup[15:0]));
        mul_b = MUL_IN_W'(sine_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // angle in turns, quadrant and table index
  assign angle    = mul_q[23:8] + wave_phase[wave_idx];
  assign r_scaled = RPW'(angle[13:0]) * RPW'(SINE_TABLE_DEPTH);
  assign k_raw    = r_scaled[RPW-1:14];
  assign k_clip   = (k_raw > DEPTH_K) ? DEPTH_K : k_raw;

  // final accumulate folded into the output step; floor to Q3.14 and saturate
  function automatic logic signed [SUM_W-1:0] sum_sat_next(
    input logic signed [ACC_W-1:0]     a,
    input logic signed [MUL_OUT_W-1:0] p
  );
    logic signed [ACC_W-1:0]    total;
    logic signed [ACC_W-14-1:0] sh;
    total = a + ACC_W'(p);
    sh    = total[ACC_W-1:14];
    if (sh > (ACC_W-14)'(SUM_MAX))      return SUM_MAX;
    else if (sh < (ACC_W-14)'(SUM_MIN)) return SUM_MIN;
    else                                return sh[SUM_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      operand <= (req_type == REQ_SAMPLE) ? position : frame_delta;
    end
    if (state == ST_TICK_MUL || state == ST_ANG_MUL || state == ST_AMP_MUL) begin
      mul_q <= mul_a * mul_b;
    end
    if (state == ST_LOOK) begin
      tbl_idx <= angle[14] ? (DEPTH_K - k_clip) : k_clip;
      negate  <= angle[15];
    end
    if (state == ST_READ) begin
      sine_q <= negate ? -signed'({1'b0, sine_tbl[tbl_idx]})
                       :  signed'({1'b0, sine_tbl[tbl_idx]});
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer, configuration, phases and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_waves <= ACTIVE_W'(6);
      wave_idx     <= '0;
      out_valid    <= 1'b0;
      acc          <= '0;
      for (int w = 0; w < MAX_WAVES; w++) begin
        wave_setup[w] <= '0;
        wave_phase[w] <= '0;
      end
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_ACTIVE) active_waves <= cfg_data[ACTIVE_W-1:0];
        for (int w = 0; w < MAX_WAVES; w++) begin
          if (cfg_index == CFG_SETUP0 + CFG_IDX_W'(w)) wave_setup[w] <= cfg_data;
        end
      end

      // drop a taken result
      if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          wave_idx <= '0;
          acc      <= '0;
          if (in_valid) begin
            if (n_waves == '0) begin
              // no active waves: a sample still needs its zero result
              state <= (req_type == REQ_SAMPLE) ? ST_ACC : ST_IDLE;
            end else begin
              state <= (req_type == REQ_SAMPLE) ? ST_ANG_MUL : ST_TICK_MUL;
            end
          end
        end
        ST_TICK_MUL: state <= ST_TICK_UPD;
        ST_TICK_UPD: begin
          wave_phase[wave_idx] <= wave_phase[wave_idx] + mul_q[27:12];
          if (last_wave) begin
            state <= ST_IDLE;
          end else begin
            wave_idx <= wave_idx + WIDX'(1);
            state    <= ST_TICK_MUL;
          end
        end
        ST_ANG_MUL: state <= ST_LOOK;
        ST_LOOK:    state <= ST_READ;
        ST_READ:    state <= ST_AMP_MUL;
        ST_AMP_MUL: state <= ST_ACC;
        ST_ACC: begin
          if (n_waves == '0 || last_wave) begin
            // hold until the output register is free
            if (out_free) begin
              out_valid  <= 1'b1;
              sample_sum <= (n_waves == '0) ? '0 : sum_sat_next(acc, mul_q);
              state      <= ST_IDLE;
            end
          end else begin
            acc      <= acc + ACC_W'(mul_q);
            wave_idx <= wave_idx + WIDX'(1);
            state    <= ST_ANG_MUL;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
